// File: sv/vdp_pkg.sv
package vdp_pkg;

  // fixed field widths
  localparam int unsigned ADDR_W   = 14;
  localparam int unsigned LINE_W   = 9;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned M_DATA_W = 24;

  localparam int unsigned VRAM_DEPTH_DEF = 16384;

  // frame geometry
  localparam logic [LINE_W-1:0] LINES_NTSC     = 9'd262;
  localparam logic [LINE_W-1:0] LINES_PAL      = 9'd313;
  localparam logic [LINE_W-1:0] LINE_FRAME_END = 9'd191;
  localparam logic [LINE_W-1:0] LINE_FRAME_INT = 9'd193;

  // register 1, bit 5 enables the frame interrupt
  localparam logic [3:0] IRQ_EN_REG = 4'd1;
  localparam int unsigned IRQ_EN_BIT = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_DATA_READ   = 3'd0,
    CMD_DATA_WRITE  = 3'd1,
    CMD_STATUS_READ = 3'd2,
    CMD_CTRL_WRITE  = 3'd3,
    CMD_LINE_TICK   = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    CODE_VRAM_READ  = 2'd0,
    CODE_VRAM_WRITE = 2'd1,
    CODE_REG_WRITE  = 2'd2,
    CODE_NO_WRITE   = 2'd3
  } code_e;

  // line timer result for the current request
  typedef struct packed {
    logic [LINE_W-1:0] line;
    logic              frame_end;
    logic              frame_int;
  } timer_evt_t;

endpackage

// File: sv/vdp_vram.sv
module vdp_vram #(
  parameter int unsigned VRAM_DEPTH = vdp_pkg::VRAM_DEPTH_DEF,
  parameter int unsigned AW         = $clog2(VRAM_DEPTH)
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             addr_i,
  input  logic [vdp_pkg::BYTE_W-1:0] wdata_i,
  output logic [vdp_pkg::BYTE_W-1:0] rdata_o
);
  import vdp_pkg::*;

  logic [BYTE_W-1:0] mem [VRAM_DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  // single port, registered read
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/vdp_line_timer.sv
module vdp_line_timer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                tick_i,
  input  logic                pal_i,
  output vdp_pkg::timer_evt_t evt_o
);
  import vdp_pkg::*;

  logic [LINE_W-1:0] line_q, line_d;
  logic [LINE_W:0]   inc;
  logic [LINE_W:0]   total;

  // next line, wrapped at the frame total (line + 1 never reaches twice the total)
  always_comb begin
    total = {1'b0, (pal_i ? LINES_PAL : LINES_NTSC)};
    inc   = {1'b0, line_q} + 10'd1;
    if (inc >= total) begin
      inc = inc - total;
    end
    line_d = tick_i ? inc[LINE_W-1:0] : line_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q <= '0;
    end else begin
      line_q <= line_d;
    end
  end

  assign evt_o.line      = line_d;
  assign evt_o.frame_end = tick_i && (line_d == LINE_FRAME_END);
  assign evt_o.frame_int = tick_i && (line_d == LINE_FRAME_INT);

endmodule

// File: sv/vdp_cpu_port_and_line_timing_core.sv
// Result: registered from an accepted request, valid in the next cycle.
// Throughput: one request per cycle while the result register can be emptied; a data
// read or a second control byte with code 0 holds the input in the fill state while
// the single VRAM port returns the read-ahead byte.
// Reset: clearing pass over the VRAM, no request taken meanwhile; configuration
// writes are taken at any time.
module vdp_cpu_port_and_line_timing_core #(
  parameter int unsigned VRAM_DEPTH = vdp_pkg::VRAM_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration: pal_video
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_data,
  // request: tdata = data_byte[7:0]; tuser = cmd[2:0]
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [vdp_pkg::BYTE_W-1:0]     s_axis_tdata,
  input  logic [vdp_pkg::CMD_W-1:0]      s_axis_tuser,
  // result: tdata = read_data[7:0], irq[8], frame_end[9], line_number[18:10], zero[23:19]
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [vdp_pkg::M_DATA_W-1:0]   m_axis_tdata
);
  import vdp_pkg::*;

  localparam int unsigned AW = $clog2(VRAM_DEPTH);
  localparam logic [ADDR_W:0] DEPTH_W = (ADDR_W+1)'(VRAM_DEPTH);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_FILL  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [AW-1:0]     clr_q, clr_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [BYTE_W-1:0] ahead_q, ahead_d;
  logic              second_q, second_d;
  logic [1:0]        code_q, code_d;
  logic              stat_int_q, stat_int_d;
  logic              irq_en_q, irq_en_d;
  logic              pal_q;

  logic                m_valid_q, m_valid_d;
  logic [M_DATA_W-1:0] m_data_q, m_data_d;

  logic              accept;
  logic [BYTE_W-1:0] rd;
  logic [ADDR_W-1:0] addr_new;
  logic              mem_en, mem_we;
  logic [AW-1:0]     mem_addr;
  logic [BYTE_W-1:0] mem_wdata, mem_rdata;
  logic              tick;
  timer_evt_t        evt;

  // address reduced modulo the VRAM depth (the user must keep the depth at least a quarter of the space; not checked)
  function automatic logic [AW-1:0] vram_index(input logic [ADDR_W-1:0] a);
    logic [ADDR_W:0] v;
    v = {1'b0, a};
    for (int k = 0; k < 3; k++) begin
      if (v >= DEPTH_W) begin
        v = v - DEPTH_W;
      end
    end
    return v[AW-1:0];
  endfunction

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE) && (!m_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign tick          = accept && (s_axis_tuser == CMD_LINE_TICK);

  vdp_line_timer u_timer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tick_i (tick),
    .pal_i  (pal_q),
    .evt_o  (evt)
  );

  vdp_vram #(
    .VRAM_DEPTH (VRAM_DEPTH),
    .AW         (AW)
  ) u_vram (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // request decode, VRAM access and register updates
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    addr_d     = addr_q;
    ahead_d    = ahead_q;
    second_d   = second_q;
    code_d     = code_q;
    stat_int_d = stat_int_q;
    irq_en_d   = irq_en_q;
    rd         = '0;
    addr_new   = {s_axis_tdata[5:0], addr_q[7:0]};
    mem_en     = 1'b0;
    mem_we     = 1'b0;
    mem_addr   = vram_index(addr_q);
    mem_wdata  = s_axis_tdata;

    unique case (state_q)
      ST_CLEAR: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == AW'(VRAM_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_FILL: begin
        ahead_d = mem_rdata;
        state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (s_axis_tuser)
            CMD_DATA_READ: begin
              rd       = ahead_q;
              second_d = 1'b0;
              mem_en   = 1'b1;
              addr_d   = addr_q + 1'b1;
              state_d  = ST_FILL;
            end
            CMD_DATA_WRITE: begin
              second_d = 1'b0;
              mem_en   = (code_q != CODE_NO_WRITE);
              mem_we   = 1'b1;
              addr_d   = addr_q + 1'b1;
            end
            CMD_STATUS_READ: begin
              rd         = {stat_int_q, 7'd0};
              second_d   = 1'b0;
              stat_int_d = 1'b0;
            end
            CMD_CTRL_WRITE: begin
              if (!second_q) begin
                second_d = 1'b1;
                addr_d   = {addr_q[ADDR_W-1:8], s_axis_tdata};
              end else begin
                second_d = 1'b0;
                code_d   = s_axis_tdata[7:6];
                addr_d   = addr_new;
                if (s_axis_tdata[7:6] == CODE_VRAM_READ) begin
                  mem_en   = 1'b1;
                  mem_addr = vram_index(addr_new);
                  addr_d   = addr_new + 1'b1;
                  state_d  = ST_FILL;
                end else if (s_axis_tdata[7:6] == CODE_REG_WRITE &&
                             s_axis_tdata[3:0] == IRQ_EN_REG) begin
                  // only register 1 bit 5 has an effect on this block
                  irq_en_d = addr_q[IRQ_EN_BIT];
                end
              end
            end
            CMD_LINE_TICK: begin
              if (evt.frame_int) begin
                stat_int_d = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;
    if (accept) begin
      m_valid_d = 1'b1;
      m_data_d  = {5'd0, evt.line, evt.frame_end, stat_int_d && irq_en_d, rd};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_q      <= '0;
      addr_q     <= '0;
      ahead_q    <= '0;
      second_q   <= 1'b0;
      code_q     <= CODE_VRAM_READ;
      stat_int_q <= 1'b0;
      irq_en_q   <= 1'b0;
      pal_q      <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      addr_q     <= addr_d;
      ahead_q    <= ahead_d;
      second_q   <= second_d;
      code_q     <= code_d;
      stat_int_q <= stat_int_d;
      irq_en_q   <= irq_en_d;
      m_valid_q  <= m_valid_d;
      if (cfg_valid && cfg_ready) begin
        pal_q <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // no request is taken while the VRAM is being cleared
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !s_axis_tready)
    else $error("request taken during VRAM clear");

  // the read-ahead refill returns to idle in the next cycle
  a_fill_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FILL |=> state_q == ST_IDLE)
    else $error("read-ahead fill did not return to idle");

  // line number stays inside the longest frame
  a_line_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> m_data_q[18:10] < LINES_PAL)
    else $error("line number out of range");

  // frame end is reported only on the last active line
  a_frame_end_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && m_data_q[9] |-> m_data_q[18:10] == LINE_FRAME_END)
    else $error("frame end on wrong line");

endmodule

// File: verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import vdp_pkg::*;

  localparam int unsigned VRAM_WORDS    = VRAM_DEPTH_DEF;
  localparam int unsigned NUM_REGS      = 11;
  localparam int unsigned FRAME_INT_BIT = 7;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned MAX_REPORTS   = 10;

  // one CPU port request; hold makes the driver wait until all replies are back
  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] data;
    bit                hold;
  } cpu_req_t;

  // reply layout, lowest bits last
  typedef struct packed {
    logic [LINE_W-1:0] line_number;
    logic              frame_end;
    logic              irq;
    logic [BYTE_W-1:0] read_data;
  } port_reply_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_valid     = 1'b0;
  logic                cfg_ready;
  logic                cfg_data      = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [BYTE_W-1:0]   s_axis_tdata  = '0;  // data_byte[7:0]
  logic [CMD_W-1:0]    s_axis_tuser  = '0;  // cmd[2:0]
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;        // read_data[7:0], irq[8], frame_end[9], line[18:10]

  vdp_cpu_port_and_line_timing_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // shadow copy of the port and timing state
  bit [BYTE_W-1:0] vram_shadow [VRAM_WORDS];
  bit [ADDR_W-1:0] addr_shadow;
  bit [BYTE_W-1:0] read_ahead_shadow;
  bit              low_byte_taken;
  code_e           code_shadow = CODE_VRAM_READ;
  bit [BYTE_W-1:0] status_shadow;
  bit [BYTE_W-1:0] regs_shadow [NUM_REGS];
  bit [LINE_W-1:0] line_shadow;
  bit              pal_shadow;

  cpu_req_t    cpu_requests[$];
  port_reply_t pending_replies[$];
  cpu_req_t    cur_req;
  port_reply_t got_reply;
  port_reply_t want_reply;

  bit back_to_back = 1'b0;
  bit req_busy     = 1'b0;
  int gap_left     = 0;
  int stall_left   = 0;
  int fail_count   = 0;
  int req_count    = 0;
  int reply_count  = 0;
  int frames_seen  = 0;
  int irqs_seen    = 0;

  // reply of the CPU port to one request, updating the shadow state
  function automatic port_reply_t cpu_port_access(logic [CMD_W-1:0] cmd,
                                                  logic [BYTE_W-1:0] b);
    port_reply_t reply;
    int unsigned lines_per_frame;
    reply = '0;
    case (cmd)
      CMD_DATA_READ: begin
        reply.read_data   = read_ahead_shadow;
        low_byte_taken    = 1'b0;
        read_ahead_shadow = vram_shadow[addr_shadow % VRAM_WORDS];
        addr_shadow       = addr_shadow + 1'b1;
      end
      CMD_DATA_WRITE: begin
        low_byte_taken = 1'b0;
        if (code_shadow != CODE_NO_WRITE)
          vram_shadow[addr_shadow % VRAM_WORDS] = b;
        addr_shadow = addr_shadow + 1'b1;
      end
      CMD_STATUS_READ: begin
        reply.read_data = status_shadow;
        low_byte_taken  = 1'b0;
        status_shadow   = '0;
      end
      CMD_CTRL_WRITE: begin
        if (!low_byte_taken) begin
          low_byte_taken   = 1'b1;
          addr_shadow[7:0] = b;
        end else begin
          low_byte_taken          = 1'b0;
          addr_shadow[ADDR_W-1:8] = b[5:0];
          code_shadow             = code_e'(b[7:6]);
          if (code_shadow == CODE_VRAM_READ) begin
            read_ahead_shadow = vram_shadow[addr_shadow % VRAM_WORDS];
            addr_shadow       = addr_shadow + 1'b1;
          end else if (code_shadow == CODE_REG_WRITE && b[3:0] < NUM_REGS) begin
            regs_shadow[b[3:0]] = addr_shadow[7:0];
          end
        end
      end
      CMD_LINE_TICK: begin
        lines_per_frame = 32'(pal_shadow ? LINES_PAL : LINES_NTSC);
        line_shadow     = LINE_W'((line_shadow + 1) % lines_per_frame);
        reply.frame_end = (line_shadow == LINE_FRAME_END);
        if (line_shadow == LINE_FRAME_INT)
          status_shadow[FRAME_INT_BIT] = 1'b1;
      end
      default: ;  // unused command: nothing moves
    endcase
    reply.irq         = status_shadow[FRAME_INT_BIT] & regs_shadow[IRQ_EN_REG][IRQ_EN_BIT];
    reply.line_number = line_shadow;
    return reply;
  endfunction

  task automatic log_failure(string msg);
    if (fail_count < MAX_REPORTS)
      $display("%t ERROR: %s", $realtime, msg);
    fail_count++;
  endtask

  // clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      req_busy = 1'b0;
      gap_left = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        pending_replies.push_back(cpu_port_access(cur_req.cmd, cur_req.data));
        req_count++;
        req_busy = 1'b0;
        gap_left = back_to_back ? 0 : $urandom_range(0, 9);
      end
      if (!req_busy) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cpu_requests.size() != 0 &&
                     (!cpu_requests[0].hold || pending_replies.size() == 0)) begin
          cur_req  = cpu_requests.pop_front();
          req_busy = 1'b1;
        end
      end
      s_axis_tvalid <= req_busy;
      s_axis_tdata  <= cur_req.data;
      s_axis_tuser  <= cur_req.cmd;
    end
  end

  // reply monitor and checker
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_reply = m_axis_tdata[$bits(port_reply_t)-1:0];
        if (pending_replies.size() == 0) begin
          log_failure($sformatf("reply with none outstanding: tdata=%h", m_axis_tdata));
        end else begin
          want_reply = pending_replies.pop_front();
          if (got_reply.read_data !== want_reply.read_data ||
              got_reply.irq !== want_reply.irq ||
              got_reply.frame_end !== want_reply.frame_end ||
              got_reply.line_number !== want_reply.line_number)
            log_failure($sformatf(
              "reply %0d: exp rd=%h irq=%b fe=%b line=%0d, got rd=%h irq=%b fe=%b line=%0d",
              reply_count, want_reply.read_data, want_reply.irq, want_reply.frame_end,
              want_reply.line_number, got_reply.read_data, got_reply.irq,
              got_reply.frame_end, got_reply.line_number));
          frames_seen += want_reply.frame_end;
          irqs_seen   += want_reply.irq;
          reply_count++;
        end
        stall_left = back_to_back ? 0 : $urandom_range(0, 9);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      m_axis_tready <= (stall_left == 0);
    end
  end

  task automatic push_req(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] b);
    cpu_req_t r;
    r.cmd  = cmd;
    r.data = b;
    r.hold = ($urandom_range(0, 99) == 0);
    cpu_requests.push_back(r);
  endtask

  task automatic ctrl_pair(logic [BYTE_W-1:0] lo, logic [BYTE_W-1:0] hi);
    push_req(CMD_CTRL_WRITE, lo);
    push_req(CMD_CTRL_WRITE, hi);
  endtask

  // block until every request is taken and every reply is back
  task automatic wait_idle();
    while (cpu_requests.size() != 0 || req_busy || s_axis_tvalid ||
           pending_replies.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_pal(bit v);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    pal_shadow = v;
  endtask

  // mostly address/code pairs followed by data traffic, some ticks, some noise
  task automatic random_phase(int n_reqs, int tick_pct);
    int made;
    int ops;
    int sel;
    logic [1:0]        code;
    logic [5:0]        hi_addr;
    logic [BYTE_W-1:0] lo;
    logic [BYTE_W-1:0] hi;
    made = 0;
    while (made < n_reqs) begin
      if ($urandom_range(0, 99) < tick_pct) begin
        push_req(CMD_LINE_TICK, 8'($urandom_range(0, 255)));
        made++;
      end else if ($urandom_range(0, 99) < 85) begin
        code    = 2'($urandom_range(0, 3));
        lo      = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) :
                                                8'($urandom_range(0, 15));
        hi_addr = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) :
                  ($urandom_range(0, 1) ? 6'h3f : 6'h00);
        if (code == CODE_REG_WRITE)
          hi = {code, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15))};
        else
          hi = {code, hi_addr};
        ctrl_pair(lo, hi);
        made += 2;
        ops = $urandom_range(0, 5);
        repeat (ops) begin
          sel = $urandom_range(0, 9);
          if (sel < 4)
            push_req(CMD_DATA_READ, 8'($urandom_range(0, 255)));
          else if (sel < 8)
            push_req(CMD_DATA_WRITE, 8'($urandom_range(0, 255)));
          else
            push_req(CMD_STATUS_READ, 8'($urandom_range(0, 255)));
          made++;
        end
      end else begin
        sel = $urandom_range(0, 2);
        if (sel == 0) begin
          // lone first byte, pair broken by a read
          push_req(CMD_CTRL_WRITE, 8'($urandom_range(0, 255)));
          push_req($urandom_range(0, 1) ? CMD_STATUS_READ : CMD_DATA_READ,
                   8'($urandom_range(0, 255)));
          made += 2;
        end else if (sel == 1) begin
          push_req(3'($urandom_range(5, 7)), 8'($urandom_range(0, 255)));
        end else begin
          sel = $urandom_range(0, 7);
          push_req(3'(sel), 8'($urandom_range(0, 255)));
          if (sel <= CMD_LINE_TICK)
            made++;
        end
      end
    end
  endtask

  // run limit
  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // stimulus sequence
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_pal(1'b0);

    // unused commands, then reads straight out of reset
    push_req(3'd5, 8'hff);
    push_req(3'd6, 8'h00);
    push_req(3'd7, 8'hff);
    push_req(CMD_STATUS_READ, 8'h00);
    push_req(CMD_DATA_READ, 8'hff);
    // enable the frame interrupt, then register indexes 15 and 11 (out of range) and 10 (the last one)
    ctrl_pair(8'h20, 8'h81);
    ctrl_pair(8'hff, 8'h8f);
    ctrl_pair(8'h5a, 8'h8b);
    ctrl_pair(8'ha5, 8'h8a);
    // write at the top address, step wraps to zero
    ctrl_pair(8'hff, 8'h7f);
    push_req(CMD_DATA_WRITE, 8'haa);
    push_req(CMD_DATA_WRITE, 8'h55);
    cpu_requests[$].hold = 1'b1;
    // broken pair, then prefetch from the top address
    push_req(CMD_CTRL_WRITE, 8'hff);
    push_req(CMD_STATUS_READ, 8'h00);
    ctrl_pair(8'hff, 8'h3f);
    push_req(CMD_DATA_READ, 8'h00);
    push_req(CMD_DATA_READ, 8'h00);
    // no-write code drops the byte but steps the address
    ctrl_pair(8'h00, 8'hc0);
    push_req(CMD_DATA_WRITE, 8'h77);
    ctrl_pair(8'h00, 8'h00);
    push_req(CMD_DATA_READ, 8'h00);
    push_req(CMD_LINE_TICK, 8'hff);
    push_req(CMD_LINE_TICK, 8'h00);
    wait_idle();

    write_pal(1'b1);
    random_phase(400, 45);
    wait_idle();
    // run the counter past the short frame, then shorten the frame under it
    if (line_shadow < LINES_NTSC)
      repeat (LINES_NTSC - line_shadow + $urandom_range(0, 20))
        push_req(CMD_LINE_TICK, 8'($urandom_range(0, 255)));
    wait_idle();
    write_pal(1'b0);
    push_req(CMD_LINE_TICK, 8'h00);
    back_to_back = 1'b1;
    random_phase(250, 30);
    wait_idle();
    back_to_back = 1'b0;

    write_pal(1'b1);
    random_phase(250, 35);
    wait_idle();
    write_pal(1'b0);
    random_phase(200, 40);
    wait_idle();

    if (pending_replies.size() != 0)
      log_failure($sformatf("%0d replies never arrived", pending_replies.size()));
    $display("Checked %0d replies to %0d requests; %0d frame ends, %0d replies with irq high.",
             reply_count, req_count, frames_seen, irqs_seen);
    $display("Ran both 262- and 313-line timing, incl. a switch with the line past 261.");
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// File: files.f
sv/vdp_pkg.sv
sv/vdp_vram.sv
sv/vdp_line_timer.sv
sv/vdp_cpu_port_and_line_timing_core.sv
verif/tb_top.sv
